[design/pls_pkg.sv]
`timescale 1ns / 1ps

package pls_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned POS_W    = 5;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 5;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic [COUNT_W-1:0]       count_out_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_LOAD  = 2'd1,
      CELL_LEFT  = 2'd2,
      CELL_RIGHT = 2'd3
   } cell_cmd_type;

endpackage

[design/pls_req_if.sv]
`timescale 1ns / 1ps

interface pls_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [4:0]         position;
   logic signed [31:0] value;

   modport source (output valid, action, position, value, input ready);
   modport sink (input valid, action, position, value, output ready);
endinterface

interface pls_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] read_value;
   logic [4:0]         element_count;

   modport source (output valid, status, read_value, element_count, input ready);
   modport sink (input valid, status, read_value, element_count, output ready);
endinterface

[design/pls_cell.sv]
`timescale 1ns / 1ps

module pls_cell (
   input  logic                  clock,
   input  pls_pkg::cell_cmd_type cmd_i,
   input  pls_pkg::data_type     new_i,
   input  pls_pkg::data_type     left_i,
   input  pls_pkg::data_type     right_i,
   output pls_pkg::data_type     value_o
);

   pls_pkg::data_type value_ff;
   pls_pkg::data_type value_in;

   always_comb begin
      case (cmd_i)
         pls_pkg::CELL_LOAD:  value_in = new_i;
         pls_pkg::CELL_LEFT:  value_in = left_i;
         pls_pkg::CELL_RIGHT: value_in = right_i;
         default:             value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_o = value_ff;

endmodule

[design/positional_list_store_top.sv]
`timescale 1ns / 1ps

// positional list store: ordered sequence of up to CAPACITY signed 32-bit entries
// req_if carries one transaction per request: action (insert, remove, read, clear),
// position and value; rsp_if returns status, read_value and element_count
// every request gives exactly one response, in request order
// the entries sit in a row of cells; on an insert each cell above the position
// takes its lower neighbor, on a remove each cell at or above it takes its upper one
// the response is registered: it is valid in the cycle after the request is taken
// throughput: one transaction per cycle while rsp_if.ready stays high, set by the single response register
// a request is taken while the response register is empty or being drained
// when the receiver stalls, the response holds and req_if.ready drops
// reset (synchronous, active high) empties the sequence and drops rsp_if.valid;
// cell contents are not cleared, entries at or above the count are never read
// only positions 0 to 31 can be addressed; element_count gives the low 5 bits

module positional_list_store_top #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   pls_req_if.sink    req_if,
   pls_rsp_if.source  rsp_if
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned WW = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;

   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   pls_pkg::status_type  status_ff;
   pls_pkg::status_type  status_in;
   pls_pkg::data_type    read_ff;
   pls_pkg::data_type    read_in;
   pls_pkg::count_out_type elem_ff;
   pls_pkg::count_out_type elem_in;

   logic                 accept;
   pls_pkg::action_type  act;
   logic [WW-1:0]        pos_w;
   logic [WW-1:0]        cnt_w;
   logic [WW-1:0]        cnt_next_w;
   logic                 ins_ok;
   logic                 rem_ok;
   logic                 rd_ok;
   pls_pkg::data_type    cell_q [CAPACITY];

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = !rsp_valid_ff || rsp_if.ready;
   assign act           = pls_pkg::action_type'(req_if.action);
   assign pos_w         = WW'(req_if.position);
   assign cnt_w         = WW'(count_ff);

   always_comb begin
      ins_ok    = 1'b0;
      rem_ok    = 1'b0;
      rd_ok     = 1'b0;
      status_in = pls_pkg::ST_DONE;
      count_in  = count_ff;
      case (act)
         pls_pkg::ACT_INSERT: begin
            if (pos_w > cnt_w) begin
               status_in = pls_pkg::ST_RANGE;
            end else if (cnt_w == WW'(CAPACITY)) begin
               status_in = pls_pkg::ST_FULL;
            end else begin
               ins_ok   = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         pls_pkg::ACT_REMOVE: begin
            if (pos_w >= cnt_w) begin
               status_in = pls_pkg::ST_RANGE;
            end else begin
               rem_ok   = 1'b1;
               count_in = count_ff - CW'(1);
            end
         end
         pls_pkg::ACT_READ: begin
            if (pos_w >= cnt_w) begin
               status_in = pls_pkg::ST_RANGE;
            end else begin
               rd_ok = 1'b1;
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   assign cnt_next_w = WW'(count_in);
   assign elem_in    = cnt_next_w[pls_pkg::COUNT_W-1:0];
   assign read_in    = rd_ok ? cell_q[pos_w[IW-1:0]] : '0;

   generate
      for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
         pls_pkg::cell_cmd_type cmd;
         pls_pkg::data_type     left_d;
         pls_pkg::data_type     right_d;

         if (k == 0) begin : g_first
            assign left_d = req_if.value;
         end else begin : g_mid_l
            assign left_d = cell_q[k-1];
         end

         if (k == CAPACITY - 1) begin : g_last
            assign right_d = '0;
         end else begin : g_mid_r
            assign right_d = cell_q[k+1];
         end

         always_comb begin
            cmd = pls_pkg::CELL_HOLD;
            if (accept && ins_ok) begin
               if (WW'(k) == pos_w) begin
                  cmd = pls_pkg::CELL_LOAD;
               end else if (WW'(k) > pos_w) begin
                  cmd = pls_pkg::CELL_LEFT;
               end
            end else if (accept && rem_ok) begin
               if (WW'(k) >= pos_w) begin
                  cmd = pls_pkg::CELL_RIGHT;
               end
            end
         end

         pls_cell u_cell (
            .clock   (clock),
            .cmd_i   (cmd),
            .new_i   (req_if.value),
            .left_i  (left_d),
            .right_i (right_d),
            .value_o (cell_q[k])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         read_ff   <= read_in;
         elem_ff   <= elem_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.read_value    = read_ff;
   assign rsp_if.element_count = elem_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      WW'(count_ff) <= WW'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      accept && ins_ok |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the count");

   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && act == pls_pkg::ACT_CLEAR |=>
         rsp_valid_ff && elem_ff == '0 && status_ff == pls_pkg::ST_DONE)
      else $error("clear response wrong");

   a_bad_pos_hold: assert property (@(posedge clock) disable iff (reset)
      accept && status_in == pls_pkg::ST_RANGE |=> $stable(count_ff))
      else $error("out of range request changed the count");

   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_if.ready)
      else $error("request stalled with empty response register");
`endif

endmodule
